### hdl/fpw_pkg.sv
package fpw_pkg;

	// default depth of the table word memory, in 64-bit words
	localparam int unsigned MEM_WORDS_DEF = 8192;

	// words in one page table (4 KiB / 8 bytes)
	localparam int unsigned TABLE_WORDS = 512;

	// entry bit positions
	localparam int unsigned BIT_PRESENT = 0;
	localparam int unsigned BIT_LARGE   = 7;

	// request kinds carried on the slave tuser
	localparam logic OP_WRITE     = 1'b0;
	localparam logic OP_TRANSLATE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROOT,
		ST_WALK,
		ST_DONE
	} fpw_state_t;

endpackage

### hdl/fpw_ram.sv
module fpw_ram
	import fpw_pkg::*;
#(
	parameter int unsigned WORDS = MEM_WORDS_DEF,
	parameter int unsigned AW    = $clog2(MEM_WORDS_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);

	logic [63:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/four_level_page_walk.sv
// Four-level x86-64 page table walker over an internal table memory of
// MEM_WORDS 64-bit words. After reset the block runs a clearing pass that
// zeroes the memory one word per cycle, with s_tready low. A write request
// (tuser = 0) stores one word at word_address[51:3] (ignored beyond the
// memory) and answers found = 0; it then waits in ST_DONE until the output
// register is free, and s_tready rises again in the same cycle that its
// response becomes valid. A translate request (tuser = 1) checks the root
// and page alignment, then reads one entry per level: it passes through
// ST_ROOT, then ST_WALK for each level read, then ST_DONE, which loads the
// output register once that is free. The levels are read one after
// another because the memory has a single read port with registered data
// and the next table address comes out of the entry just read. A single
// bound-check comparator and index adder form each read address, shared
// by the root and all lower levels. A finished response waits in the
// output register while the next request is accepted.
module four_level_page_walk
	import fpw_pkg::*;
#(
	parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// slave request stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// [51:0] word_address, [115:52] write_data,
	// [167:116] root_table_address, [231:168] virtual_address
	input  logic [231:0] s_tdata,
	// [0] opcode
	input  logic [0:0]   s_tuser,
	// master response stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// [63:0] leaf_entry
	output logic [63:0]  m_tdata,
	// [0] found
	output logic [0:0]   m_tuser
);

	localparam int unsigned AW = $clog2(MEM_WORDS);
	// a table starting at word index <= LIMIT lies wholly in memory
	localparam logic [48:0] LIMIT   = 49'(MEM_WORDS - TABLE_WORDS);
	localparam logic [48:0] DEPTH_W = 49'(MEM_WORDS);
	localparam logic [AW-1:0] LAST_WORD = AW'(MEM_WORDS - 1);

	// request fields
	logic        opcode;
	logic [51:0] word_address;
	logic [63:0] write_data;
	logic [51:0] root_table_address;
	logic [63:0] virtual_address;

	assign opcode             = s_tuser[0];
	assign word_address       = s_tdata[51:0];
	assign write_data         = s_tdata[115:52];
	assign root_table_address = s_tdata[167:116];
	assign virtual_address    = s_tdata[231:168];

	fpw_state_t state_q, state_d;

	logic [AW-1:0] clr_cnt_q;
	logic [1:0]    lvl_q, lvl_d;
	logic [51:0]   root_q;
	logic [63:0]   va_q;
	logic          res_found_q, res_found_d;
	logic [63:0]   res_entry_q, res_entry_d;

	logic          m_valid_q;
	logic          m_found_q;
	logic [63:0]   m_entry_q;

	// memory port signals
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [63:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [63:0]   mem_rdata;

	// shared address unit: bound check plus slot index add
	logic [48:0]   cand_first;
	logic [8:0]    cand_idx;
	logic          cand_in_range;
	logic [AW-1:0] cand_addr;

	logic          accept;
	logic          out_load;
	logic [48:0]   wr_word;
	logic          entry_bad;

	function automatic logic [8:0] va_index(input logic [63:0] va, input logic [1:0] lvl);
		logic [8:0] idx;
		case (lvl)
			2'd0:    idx = va[47:39];
			2'd1:    idx = va[38:30];
			2'd2:    idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

	assign accept  = s_tvalid && s_tready;
	assign wr_word = word_address[51:3];

	// root table for the first read, the entry's next table afterwards
	assign cand_first    = (state_q == ST_ROOT) ? root_q[51:3] : {mem_rdata[51:12], 9'd0};
	assign cand_idx      = va_index(va_q, (state_q == ST_ROOT) ? 2'd0 : lvl_q + 2'd1);
	assign cand_in_range = (cand_first <= LIMIT);
	assign cand_addr     = cand_first[AW-1:0] + AW'(cand_idx);

	// non-present entry, or large page above the leaf level
	assign entry_bad = !mem_rdata[BIT_PRESENT] || ((lvl_q != 2'd3) && mem_rdata[BIT_LARGE]);

	assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_tready);

	always_comb begin
		state_d     = state_q;
		lvl_d       = lvl_q;
		res_found_d = res_found_q;
		res_entry_d = res_entry_q;
		s_tready    = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = clr_cnt_q;
		mem_wdata   = '0;
		mem_re      = 1'b0;
		mem_raddr   = cand_addr;

		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_cnt_q == LAST_WORD) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					res_found_d = 1'b0;
					res_entry_d = '0;
					if (opcode == OP_WRITE) begin
						mem_we    = (wr_word < DEPTH_W);
						mem_waddr = wr_word[AW-1:0];
						mem_wdata = write_data;
						state_d   = ST_DONE;
					end else begin
						state_d = ST_ROOT;
					end
				end
			end
			ST_ROOT: begin
				if ((root_q == '0) || (va_q[11:0] != '0) || !cand_in_range) begin
					state_d = ST_DONE;
				end else begin
					mem_re  = 1'b1;
					lvl_d   = 2'd0;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (entry_bad) begin
					state_d = ST_DONE;
				end else if (lvl_q == 2'd3) begin
					res_found_d = 1'b1;
					res_entry_d = mem_rdata;
					state_d     = ST_DONE;
				end else if (!cand_in_range) begin
					state_d = ST_DONE;
				end else begin
					mem_re = 1'b1;
					lvl_d  = lvl_q + 2'd1;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			lvl_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		res_found_q <= res_found_d;
		res_entry_q <= res_entry_d;
		if (accept) begin
			root_q <= root_table_address;
			va_q   <= virtual_address;
		end
		if (out_load) begin
			m_found_q <= res_found_q;
			m_entry_q <= res_entry_q;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_entry_q;
	assign m_tuser[0] = m_found_q;

	fpw_ram #(
		.WORDS(MEM_WORDS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// a found response always carries a present entry
	a_found_present: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tdata[BIT_PRESENT])
		else $error("found response with non-present leaf");

	// a miss or write response carries a zero entry
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("non-found response with nonzero entry");

	// no request is taken while the memory is being cleared
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("request accepted during clearing pass");

	// consecutive walk cycles step one level down
	a_level_step: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WALK) && $past(state_q == ST_WALK)) |-> (lvl_q == $past(lvl_q) + 2'd1))
		else $error("walk level did not advance");

endmodule
